FILE: hdl/itrd_pkg.sv
// Shared types, widths and character coding for the integer to radix text converter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package itrd_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_W     = $clog2(VALUE_WIDTH + 1);
   localparam int IDX_W       = $clog2(VALUE_WIDTH);
   localparam int BITCNT_W    = $clog2(VALUE_WIDTH);
   localparam int RADIX_W     = 5;
   localparam int DIGIT_W     = 4;
   localparam int CHAR_W      = 7;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd87;

   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   addr;
      logic [DIGIT_W-1:0] data;
   } digit_wr_type;

   typedef struct packed {
      logic               go;
      logic               negative;
      logic [COUNT_W-1:0] count;
   } emit_ctrl_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d < 4'd10) begin
         return CHAR_ZERO + d_ext;
      end
      return CHAR_LETTER + d_ext;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/integer_to_radix_digits.sv
// Top level of the integer to radix text converter: request control and radix register.
// Depends on itrd_pkg, itrd_div and itrd_emit.
`timescale 1ns / 1ps
`default_nettype none
// A request is taken when start is high and busy is low; busy stays high until the last
// character has gone out. Characters appear on rsp_character one per cycle while rsp_strobe
// is high, a leading '-' for negative values, and rsp_is_last marks the final one; the
// receiver cannot stall them. Each digit of a nonzero value costs one pass of the bit-serial
// divider; zero is stored as a single digit without one. The radix is written through
// csr_valid/csr_data while idle; csr_ready is low while busy or while a request is
// presented. Values below 2 act as 2, above 16 as 16.
module integer_to_radix_digits (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [itrd_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                             rsp_strobe,
   output logic [itrd_pkg::CHAR_W-1:0]      rsp_character,
   output logic                             rsp_is_last,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [itrd_pkg::RADIX_W-1:0]     csr_data
);
   import itrd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [1:0] ST_WAIT = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [RADIX_W-1:0]     radix_ff, radix_in;
   logic                   neg_ff, neg_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [RADIX_W-1:0]     eff_radix;
   logic [VALUE_WIDTH-1:0] mag;
   logic                   accept;
   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quotient;
   logic                   div_q_nz;
   logic [DIGIT_W-1:0]     div_rem;
   logic                   emit_busy;
   digit_wr_type           digit_wr;
   emit_ctrl_type          emit_ctrl;

   // The radix must not change while a value is being divided down.
   assign csr_ready = ~busy & ~start;
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start & ~busy;

   always_comb begin
      priority if (radix_ff < RADIX_MIN) begin
         eff_radix = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         eff_radix = RADIX_MAX;
      end else begin
         eff_radix = radix_ff;
      end
   end

   // The negation wraps for the most negative value, which still reads correctly as unsigned.
   assign mag = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;

   always_comb begin
      state_in       = state_ff;
      radix_in       = (csr_valid & csr_ready) ? csr_data : radix_ff;
      neg_in         = neg_ff;
      count_in       = count_ff;
      div_start      = 1'b0;
      div_dividend   = mag;
      digit_wr.we    = 1'b0;
      digit_wr.addr  = count_ff[IDX_W-1:0];
      digit_wr.data  = div_rem;
      emit_ctrl.go       = 1'b0;
      emit_ctrl.negative = neg_ff;
      emit_ctrl.count    = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in = req_value[VALUE_WIDTH-1];
               if (mag == '0) begin
                  digit_wr.we   = 1'b1;
                  digit_wr.addr = '0;
                  digit_wr.data = '0;
                  count_in      = COUNT_W'(1);
                  state_in      = ST_EMIT;
               end else begin
                  count_in  = '0;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            div_dividend = div_quotient;
            if (div_done) begin
               digit_wr.we = 1'b1;
               count_in    = count_ff + 1'b1;
               if (div_q_nz) begin
                  div_start = 1'b1;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            emit_ctrl.go = 1'b1;
            state_in     = ST_WAIT;
         end
         ST_WAIT: begin
            if (!emit_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_RESET;
         neg_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
         neg_ff   <= neg_in;
         count_ff <= count_in;
      end
   end

   itrd_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend    (div_dividend),
      .divisor     (eff_radix),
      .done        (div_done),
      .quotient    (div_quotient),
      .quotient_nz (div_q_nz),
      .remainder   (div_rem)
   );

   itrd_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .digit_wr      (digit_wr),
      .ctrl          (emit_ctrl),
      .emit_busy     (emit_busy),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_is_last   (rsp_is_last)
   );

endmodule
`default_nettype wire

FILE: hdl/itrd_div.sv
// Bit-serial restoring divider: divides the magnitude by the radix, one quotient bit a cycle.
// Depends on itrd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module itrd_div (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   input  wire  [itrd_pkg::VALUE_WIDTH-1:0]      dividend,
   input  wire  [itrd_pkg::RADIX_W-1:0]          divisor,
   output logic                                  done,
   output logic [itrd_pkg::VALUE_WIDTH-1:0]      quotient,
   output logic                                  quotient_nz,
   output logic [itrd_pkg::DIGIT_W-1:0]          remainder
);
   import itrd_pkg::*;

   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [BITCNT_W-1:0]    cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] q_ff, q_in;
   logic [RADIX_W-1:0]     r_ff, r_in;
   logic [RADIX_W-1:0]     div_ff, div_in;
   logic                   nz_ff, nz_in;
   logic [RADIX_W-1:0]     rem_shift;
   logic                   ge;

   // The partial remainder stays below the divisor, so four bits plus the new bit suffice.
   assign rem_shift = {r_ff[DIGIT_W-1:0], q_ff[VALUE_WIDTH-1]};
   assign ge        = (rem_shift >= div_ff);

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      div_in  = div_ff;
      nz_in   = nz_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         q_in   = dividend;
         r_in   = '0;
         div_in = divisor;
         nz_in  = 1'b0;
      end else if (run_ff) begin
         q_in  = {q_ff[VALUE_WIDTH-2:0], ge};
         r_in  = ge ? (rem_shift - div_ff) : rem_shift;
         nz_in = nz_ff | ge;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == BITCNT_W'(VALUE_WIDTH - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      div_ff <= div_in;
      nz_ff  <= nz_in;
   end

   assign done        = done_ff;
   assign quotient    = q_ff;
   assign quotient_nz = nz_ff;
   assign remainder   = r_ff[DIGIT_W-1:0];

endmodule
`default_nettype wire

FILE: hdl/itrd_emit.sv
// Digit store and character emitter: replays stored digits most significant first.
// Depends on itrd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module itrd_emit (
   input  wire                              clock,
   input  wire                              reset,
   input  itrd_pkg::digit_wr_type           digit_wr,
   input  itrd_pkg::emit_ctrl_type          ctrl,
   output logic                             emit_busy,
   output logic                             rsp_strobe,
   output logic [itrd_pkg::CHAR_W-1:0]      rsp_character,
   output logic                             rsp_is_last
);
   import itrd_pkg::*;

   logic [DIGIT_W-1:0] store [VALUE_WIDTH];
   logic               active_ff, active_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               dash_ff, dash_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               rd_last_ff, rd_last_in;
   logic [DIGIT_W-1:0] rd_data_ff;
   logic [COUNT_W-1:0] count_m1;

   assign count_m1 = ctrl.count - 1'b1;

   always_ff @(posedge clock) begin
      if (digit_wr.we) begin
         store[digit_wr.addr] <= digit_wr.data;
      end
      rd_data_ff <= store[idx_ff];
   end

   always_comb begin
      active_in  = active_ff;
      idx_in     = idx_ff;
      dash_in    = 1'b0;
      rd_vld_in  = 1'b0;
      rd_last_in = 1'b0;
      if (ctrl.go) begin
         active_in = 1'b1;
         idx_in    = count_m1[IDX_W-1:0];
         dash_in   = ctrl.negative;
      end else if (active_ff) begin
         rd_vld_in  = 1'b1;
         rd_last_in = (idx_ff == '0);
         if (idx_ff == '0) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         dash_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         dash_ff   <= dash_in;
         rd_vld_ff <= rd_vld_in;
      end
      idx_ff     <= idx_in;
      rd_last_ff <= rd_last_in;
   end

   // The sign goes out in the cycle before the first digit read completes.
   assign rsp_strobe    = dash_ff | rd_vld_ff;
   assign rsp_character = rd_vld_ff ? digit_char(rd_data_ff) : CHAR_MINUS;
   assign rsp_is_last   = rd_vld_ff & rd_last_ff;
   assign emit_busy     = active_ff | dash_ff | rd_vld_ff;

endmodule
`default_nettype wire

FILE: test/tb_integer_to_radix_digits.sv
// Self-checking testbench for integer_to_radix_digits: drives signed values and radix writes,
// predicts each character of the text form and checks every strobed character in order.
// Depends on itrd_pkg and the integer_to_radix_digits RTL.
`timescale 1ns / 1ps

module tb_integer_to_radix_digits;
   import itrd_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 40;

   localparam logic [CHAR_W-1:0] ASCII_DASH = 7'h2d;
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_A    = 7'h61;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              is_last;
   } text_char_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   logic [VALUE_WIDTH-1:0] req_value = '0;
   logic                   csr_valid = 1'b0;
   logic [RADIX_W-1:0]     csr_data  = '0;
   logic                   busy;
   logic                   rsp_strobe;
   logic [CHAR_W-1:0]      rsp_character;
   logic                   rsp_is_last;
   logic                   csr_ready;

   text_char_type      pending_chars[$];
   logic [RADIX_W-1:0] radix_reg      = RADIX_RESET;
   bit                 idle_enabled   = 1'b0;
   int                 failures       = 0;
   int                 values_sent    = 0;
   int                 chars_checked  = 0;
   int                 radix_settings = 1;
   int unsigned        cycle_count    = 0;

   integer_to_radix_digits uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_is_last   (rsp_is_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int effective_base();
      if (radix_reg < 2) begin
         return 2;
      end
      if (radix_reg > 16) begin
         return 16;
      end
      return int'(radix_reg);
   endfunction

   // Appends the characters of one value, most significant first, to the expected text.
   function automatic void render_value(input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] mag;
      logic [DIGIT_W-1:0]     digits [VALUE_WIDTH];
      int                     base;
      int                     n;
      text_char_type          c;
      base = effective_base();
      mag  = value[VALUE_WIDTH-1] ? -value : value;
      n    = 0;
      // Zero still yields one digit, since the loop body runs once.
      do begin
         digits[n] = DIGIT_W'(mag % base);
         mag       = mag / base;
         n++;
      end while (mag != 0);
      if (value[VALUE_WIDTH-1]) begin
         c.character = ASCII_DASH;
         c.is_last   = 1'b0;
         pending_chars.push_back(c);
      end
      for (int i = n - 1; i >= 0; i--) begin
         c.character = (digits[i] < 10) ? CHAR_W'(ASCII_ZERO + digits[i])
                                        : CHAR_W'(ASCII_A + digits[i] - 10);
         c.is_last   = (i == 0);
         pending_chars.push_back(c);
      end
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pick_value(input int base);
      longint                 p;
      int                     k;
      logic [VALUE_WIDTH-1:0] v;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = $urandom_range(0, 64) - 32;
         2: begin
            // Values either side of a power of the radix, where the digit count changes.
            p = 1;
            k = $urandom_range(1, 31);
            repeat (k) begin
               if (p * base < 64'h1_0000_0000) begin
                  p = p * base;
               end
            end
            v = p[31:0] + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) begin
               v = -v;
            end
         end
         3: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7fff_ffff;
               2: v = '0;
               default: v = '1;
            endcase
         end
         default: begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1)) begin
               v = -v;
            end
         end
      endcase
      return v;
   endfunction

   // start is left high after acceptance so that a following request can go straight out.
   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      render_value(value);
      values_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_idle();
      if (idle_enabled && $urandom_range(0, 2) == 0) begin
         if ($urandom_range(0, 1)) begin
            // Let the block finish first so that the gap falls on its idle phase.
            start <= 1'b0;
            do @(posedge clock); while (busy);
         end
         pause_sender($urandom_range(1, 3));
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy);
   endtask

   task automatic write_radix(input logic [RADIX_W-1:0] r);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= r;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      radix_reg = r;
      radix_settings++;
   endtask

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_strobe) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected character: character=%0h is_last=%0b", rsp_character,
                   rsp_is_last);
            failures++;
         end else begin
            want = pending_chars.pop_front();
            chars_checked++;
            if (rsp_character !== want.character) begin
               $error("character: expected %0h, got %0h", want.character, rsp_character);
               failures++;
            end
            if (rsp_is_last !== want.is_last) begin
               $error("is_last: expected %0b, got %0b", want.is_last, rsp_is_last);
               failures++;
            end
         end
      end
   end

   // Decimal conversion straight after reset, including both ends of the value range.
   task automatic test_default_radix();
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'hffff_ffff);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'h7fff_ffff);
      send_value(32'h8000_0000);
      send_value(32'd12345);
      send_value(-32'd987);
   endtask

   task automatic test_radix_limits();
      write_radix(5'd2);
      send_value(32'h8000_0000);
      send_value(32'h7fff_ffff);
      send_value(32'd5);
      write_radix(5'd16);
      send_value(32'hdead_beef);
      send_value(32'd255);
      send_value(32'hffff_ffff);
      // Radix settings below two act as two, those above sixteen as sixteen.
      write_radix(5'd0);
      send_value(32'd6);
      write_radix(5'd1);
      send_value(32'd7);
      write_radix(5'd17);
      send_value(32'd255);
      write_radix(5'd31);
      send_value(32'h7fff_ffff);
   endtask

   task automatic test_random_phases();
      logic [RADIX_W-1:0] phase_radix [10];
      phase_radix  = '{5'd3, 5'd10, 5'd16, 5'd2, 5'd7, 5'd31, 5'd5, 5'd0, 5'd12, 5'd8};
      idle_enabled = 1'b1;
      foreach (phase_radix[p]) begin
         write_radix(phase_radix[p]);
         // Every other phase runs without gaps between requests.
         idle_enabled = (p % 2 == 0);
         for (int i = 0; i < 12; i++) begin
            if (p == 4 && i == 7) begin
               drain();
            end
            send_value(pick_value(effective_base()));
            maybe_idle();
         end
      end
      idle_enabled = 1'b0;
   endtask

   task automatic test_back_to_back();
      write_radix(5'd10);
      for (int i = 0; i < 10; i++) begin
         send_value(pick_value(effective_base()));
      end
      write_radix(5'd16);
      for (int i = 0; i < 10; i++) begin
         send_value(pick_value(effective_base()));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_radix();
      test_radix_limits();
      test_random_phases();
      test_back_to_back();

      start <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0) begin
         $error("%0d expected characters never arrived", pending_chars.size());
         failures++;
      end

      $display("Converted %0d values into %0d checked characters over %0d radix settings,",
               values_sent, chars_checked, radix_settings);
      $display("including out-of-range radices and both extremes of the signed range.");
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/itrd_pkg.sv
hdl/itrd_div.sv
hdl/itrd_emit.sv
hdl/integer_to_radix_digits.sv
test/tb_integer_to_radix_digits.sv
